/* rtl/csdm_pkg.sv */
// Shared types, constants and arithmetic helpers for the concentric disk map.
package csdm_pkg;

	// CORDIC datapath fraction bits and iteration count
	localparam int COORD_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	// Angle format and derived widths
	localparam int ANG_FRAC = 30;
	localparam int QW       = ANG_FRAC + 1;          // quotient bits, ratio <= 1.0
	localparam int RW       = 17;                    // radius / numerator / denominator
	localparam int ZW       = 32;                    // residual angle, signed
	localparam int XW       = COORD_BITS + 3;        // CORDIC x/y, signed
	localparam int IW       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam logic [29:0] PI4_Q30   = 30'd843314857;
	localparam logic [29:0] KGAIN_Q30 = 30'd652032875;

	// Start value scaling: x0 = (r*K + 2^(45-CB)) >> (46-CB)
	localparam int X0_RND_POS = 45 - COORD_BITS;
	localparam int X0_SHIFT   = 46 - COORD_BITS;

	// Output conversion to Q1.15
	localparam int SH_R   = (COORD_BITS > 15) ? COORD_BITS - 15 : 0;
	localparam int SH_L   = (COORD_BITS < 15) ? 15 - COORD_BITS : 0;
	localparam int Q_RND  = (SH_R > 0) ? (1 << (SH_R - 1)) : 0;
	localparam int OW     = XW + 2 + SH_L;

	localparam logic [31:0] ATAN_TAB [0:10] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
		32'd1048576
	};

	// One divider cell's view of a request
	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RW-1:0] den;
		logic [QW-1:0] dvd;
		logic [QW-1:0] quo;
		logic [1:0]    quad;
		logic [RW-1:0] rad;
		logic          neg;
		logic          zero;
	} div_t;

	// One CORDIC cell's view of a request
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [IW-1:0]        idx;
		logic [1:0]           quad;
	} cordic_t;

	function automatic logic [ZW-1:0] atan_entry(input logic [IW-1:0] i);
		logic [5:0] ie;
		ie = 6'(i);
		if (ie <= 6'd10)
			return ATAN_TAB[ie[3:0]];
		else if (ie <= 6'(ANG_FRAC))
			return 32'h1 << (6'(ANG_FRAC) - ie);
		else
			return '0;
	endfunction

	// Round half up to Q1.15 and saturate
	function automatic logic signed [15:0] sat_q15(input logic signed [XW:0] v);
		logic signed [OW-1:0] t;
		t = OW'(v);
		t = t + OW'(Q_RND);
		t = t >>> SH_R;
		t = t <<< SH_L;
		if (t > OW'(32767))
			return 16'sh7fff;
		else if (t < -OW'(32768))
			return -16'sh8000;
		else
			return 16'(t);
	endfunction

endpackage

/* rtl/csdm_div_cell.sv */
// One restoring-division cell: retires one quotient bit per request.
module csdm_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  csdm_pkg::div_t      in_d,
	output logic                out_vld,
	output csdm_pkg::div_t      out_d
);
	import csdm_pkg::*;

	logic [RW:0]   rem2;
	logic          ge;
	logic [RW:0]   diff;
	div_t          nxt;

	always_comb begin
		rem2 = {in_d.rem, in_d.dvd[QW-1]};
		diff = rem2 - {1'b0, in_d.den};
		ge   = (rem2 >= {1'b0, in_d.den});
		nxt     = in_d;
		nxt.rem = ge ? diff[RW-1:0] : rem2[RW-1:0];
		nxt.dvd = {in_d.dvd[QW-2:0], 1'b0};
		nxt.quo = {in_d.quo[QW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

/* rtl/csdm_cordic_cell.sv */
// One rotation-mode CORDIC cell: a single micro-rotation per request.
module csdm_cordic_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  csdm_pkg::cordic_t   in_d,
	output logic                out_vld,
	output csdm_pkg::cordic_t   out_d
);
	import csdm_pkg::*;

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic [ZW-1:0]        at;
	cordic_t              nxt;

	always_comb begin
		xs  = in_d.x >>> in_d.idx;
		ys  = in_d.y >>> in_d.idx;
		at  = atan_entry(in_d.idx);
		nxt = in_d;
		if (!in_d.z[ZW-1]) begin
			nxt.x = in_d.x - ys;
			nxt.y = in_d.y + xs;
			nxt.z = in_d.z - $signed(at);
		end else begin
			nxt.x = in_d.x + ys;
			nxt.y = in_d.y - xs;
			nxt.z = in_d.z + $signed(at);
		end
		nxt.idx = in_d.idx + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

/* rtl/concentric_square_to_disk_map_top.sv */
// Top level of the concentric square-to-disk map pipeline.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------
//  in      | in_valid / in_stall   | sample_u, sample_v (Q0.16)
//  out     | out_valid / out_stall | disk_x, disk_y (Q1.15)
//
// One request per cycle is taken in steady state while no held result stalls the chain;
// every request returns one result after passing through sector setup, QW divider cells,
// the scaling multipliers, CORDIC_STEPS rotation cells and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// A held result stalls the whole chain in one step: every stage keeps its
// contents and in_stall rises in the same cycle.
module concentric_square_to_disk_map_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sample_u,
	input  logic [15:0] sample_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] disk_x,
	output logic signed [15:0] disk_y
);
	import csdm_pkg::*;

	// Global advance: the chain moves whenever the output slot is free or drained
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// ---------------------------------------------------------------
	// Sector setup: map to [-1,1]^2, pick sector, radius and ratio operands
	// ---------------------------------------------------------------
	logic signed [18:0] a;
	logic signed [18:0] b;
	logic [RW-1:0]      am;
	logic [RW-1:0]      bm;
	logic [1:0]         quad;
	logic               odd;
	div_t               setup;

	always_comb begin
		a    = 19'($signed({2'b00, sample_u, 1'b0})) - 19'sd65536;
		b    = 19'($signed({2'b00, sample_v, 1'b0})) - 19'sd65536;
		am   = a[18] ? RW'(-a) : RW'(a);
		bm   = b[18] ? RW'(-b) : RW'(b);
		if (a > -b) begin
			quad = (a > b) ? 2'd0 : 2'd1;
		end else begin
			quad = (a < b) ? 2'd2 : 2'd3;
		end
		odd  = quad[0];
		setup.rad  = odd ? bm : am;
		setup.den  = odd ? bm : am;
		// dividend is n*2^30 + d/2; its top part n/2 seeds the remainder
		setup.rem  = RW'(odd ? am >> 1 : bm >> 1);
		setup.dvd  = {(odd ? am[0] : bm[0]), 14'd0, setup.den[RW-1:1]};
		setup.quo  = '0;
		setup.quad = quad;
		setup.neg  = odd ? ((a > 0) ^ b[18]) : (b[18] ^ a[18]);
		setup.zero = (am == '0) || (bm == '0);
	end

	logic div_vld [0:QW];
	div_t div_d   [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld[0] <= 1'b0;
		end else if (adv) begin
			div_vld[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_d[0] <= setup;
		end
	end

	// ---------------------------------------------------------------
	// Divider chain: one quotient bit per cell, most significant first
	// ---------------------------------------------------------------
	genvar gi;
	generate
		for (gi = 0; gi < QW; gi++) begin : g_div
			csdm_div_cell u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.in_vld (div_vld[gi]),
				.in_d   (div_d[gi]),
				.out_vld(div_vld[gi+1]),
				.out_d  (div_d[gi+1])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Scaling: ratio to radians, radius times CORDIC gain
	// ---------------------------------------------------------------
	logic [QW+29:0]  ang_prod;
	logic [QW+29:0]  ang_rnd;
	logic [29:0]     ang_mag;
	logic [RW+30:0]  x0_prod;
	cordic_t         cor_start;

	always_comb begin
		ang_prod = (QW+30)'(div_d[QW].quo) * (QW+30)'(PI4_Q30);
		ang_rnd  = ang_prod + (QW+30)'(1 << (ANG_FRAC - 1));
		ang_mag  = ang_rnd[ANG_FRAC +: 30];
		x0_prod  = (RW+31)'(div_d[QW].rad) * (RW+31)'(KGAIN_Q30)
			+ ((RW+31)'(1) << X0_RND_POS);
		cor_start.x    = XW'($signed({1'b0, x0_prod >> X0_SHIFT}));
		cor_start.y    = '0;
		if (div_d[QW].zero)
			cor_start.z = '0;
		else if (div_d[QW].neg)
			cor_start.z = -$signed(ZW'(ang_mag));
		else
			cor_start.z = $signed(ZW'(ang_mag));
		cor_start.idx  = '0;
		cor_start.quad = div_d[QW].quad;
	end

	logic    cor_vld [0:CORDIC_STEPS];
	cordic_t cor_d   [0:CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cor_vld[0] <= 1'b0;
		end else if (adv) begin
			cor_vld[0] <= div_vld[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cor_d[0] <= cor_start;
		end
	end

	// ---------------------------------------------------------------
	// CORDIC chain: one micro-rotation per cell
	// ---------------------------------------------------------------
	generate
		for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cor
			csdm_cordic_cell u_cor (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.in_vld (cor_vld[gi]),
				.in_d   (cor_d[gi]),
				.out_vld(cor_vld[gi+1]),
				.out_d  (cor_d[gi+1])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Sector rotation by multiples of pi/2, round and saturate
	// ---------------------------------------------------------------
	logic signed [XW:0] cx;
	logic signed [XW:0] sy;
	logic signed [XW:0] ox;
	logic signed [XW:0] oy;

	always_comb begin
		cx = (XW+1)'(cor_d[CORDIC_STEPS].x);
		sy = (XW+1)'(cor_d[CORDIC_STEPS].y);
		case (cor_d[CORDIC_STEPS].quad)
			2'd0: begin
				ox = cx;
				oy = sy;
			end
			2'd1: begin
				ox = -sy;
				oy = cx;
			end
			2'd2: begin
				ox = -cx;
				oy = -sy;
			end
			default: begin
				ox = sy;
				oy = -cx;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= cor_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disk_x <= sat_q15(ox);
			disk_y <= sat_q15(oy);
		end
	end

endmodule

/* tb/tb_disk_checker.sv */
// Checker that predicts and compares concentric disk map results.
`timescale 1ns / 1ps

module tb_disk_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [15:0]        sample_u,
	input  logic [15:0]        sample_v,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] disk_x,
	input  logic signed [15:0] disk_y,
	output int                 fail_count,
	output int                 pending
);
	import csdm_pkg::COORD_BITS;
	import csdm_pkg::CORDIC_STEPS;

	localparam int ANG_BITS = 30;
	localparam longint PI4_FIX = 64'd843314857;
	localparam longint GAIN_FIX = 64'd652032875;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} disk_pt_t;

	disk_pt_t disk_q[$];

	function automatic longint arc_step(int i);
		longint tab [0:10];
		tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576};
		if (i <= 10)
			return tab[i];
		else if (i <= ANG_BITS)
			return longint'(1) << (ANG_BITS - i);
		return 0;
	endfunction

	function automatic logic signed [15:0] round_q15(longint v);
		int sh;
		sh = COORD_BITS - 15;
		if (sh > 0)
			v = (v + (longint'(1) << (sh - 1))) >>> sh;
		else if (sh < 0)
			v = v * (longint'(1) << (-sh));
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic disk_pt_t map_to_disk(logic [15:0] u, logic [15:0] v);
		longint a, b, r, num, den, x, y, z, xs, ys, ox, oy;
		longint unsigned n, d, q, m;
		int sector;
		disk_pt_t p;
		a = 2 * longint'(u) - 65536;
		b = 2 * longint'(v) - 65536;
		if (a > -b) begin
			if (a > b) begin
				sector = 0; r = a; num = b; den = a;
			end else begin
				sector = 1; r = b; num = -a; den = b;
			end
		end else begin
			if (a < b) begin
				sector = 2; r = -a; num = b; den = a;
			end else begin
				sector = 3; r = -b; num = -a; den = b;
			end
		end
		z = 0;
		if (den != 0 && num != 0) begin
			n = num < 0 ? -num : num;
			d = den < 0 ? -den : den;
			q = ((n << ANG_BITS) + d / 2) / d;
			m = (q * PI4_FIX + (64'd1 << (ANG_BITS - 1))) >> ANG_BITS;
			z = ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
		end
		x = (r * GAIN_FIX + (longint'(1) << (45 - COORD_BITS))) >>> (46 - COORD_BITS);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arc_step(i);
			end else begin
				x += ys; y -= xs; z += arc_step(i);
			end
		end
		case (sector)
			0: begin ox = x;  oy = y;  end
			1: begin ox = -y; oy = x;  end
			2: begin ox = -x; oy = -y; end
			default: begin ox = y; oy = -x; end
		endcase
		p.x = round_q15(ox);
		p.y = round_q15(oy);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		disk_pt_t e;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			disk_q.delete();
		end else begin
			if (in_valid && !in_stall)
				disk_q.insert(disk_q.size(), map_to_disk(sample_u, sample_v));
			if (out_valid && !out_stall) begin
				if (disk_q.size() == 0) begin
					$error("disk result with no request pending: x=%0d y=%0d", disk_x, disk_y);
					fail_count <= fail_count + 1;
				end else begin
					e = disk_q.pop_front();
					if (e.x !== disk_x || e.y !== disk_y) begin
						if (e.x !== disk_x)
							$error("disk_x expected %0d actual %0d", e.x, disk_x);
						if (e.y !== disk_y)
							$error("disk_y expected %0d actual %0d", e.y, disk_y);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= disk_q.size();
		end
	end
endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the concentric disk map testbench.
`timescale 1ns / 1ps

module tb_top;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        sample_u;
	logic [15:0]        sample_v;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] disk_x;
	logic signed [15:0] disk_y;
	int                 fail_count;
	int                 pending;
	int                 cycle_cnt = 0;
	bit                 calm;       // no idling on either side
	bit                 hold_off;   // receiver long stall request

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	concentric_square_to_disk_map_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_u  (sample_u),
		.sample_v  (sample_v),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.disk_x    (disk_x),
		.disk_y    (disk_y)
	);

	tb_disk_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_u   (sample_u),
		.sample_v   (sample_v),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.disk_x     (disk_x),
		.disk_y     (disk_y),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver: random stall, off while calm, held high for a long stretch on request.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (hold_off)
			out_stall <= 1'b1;
		else if (calm)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 20);
	end

	// Offer one request; idle randomly first, then hold it until accepted.
	task automatic send_request(input logic [15:0] u, input logic [15:0] v);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_u <= u;
		sample_v <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0] corner [0:4];
		logic [15:0] u;
		logic [15:0] v;
		int          stall_start;
		corner = '{16'h0000, 16'h8000, 16'hffff, 16'h0001, 16'h7fff};
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_u = '0;
		sample_v = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner and axis points, the origin, full radius and both diagonals.
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				send_request(corner[i], corner[j]);

		// Pause the sender until every result is back.
		drain_results();

		// Long receiver hold-off while the sender keeps offering, filling the pipe.
		fork
			begin
				hold_off = 1'b1;
				stall_start = cycle_cnt;
				while (cycle_cnt - stall_start < 200)
					@(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int k = 0; k < 80; k++)
					send_request(16'($urandom), 16'($urandom));
			end
		join

		// Random points; some on diagonals and axes, with a calm stretch mid-way.
		for (int k = 0; k < 420; k++) begin
			calm = (k >= 150 && k < 250);
			u = 16'($urandom);
			case ($urandom_range(5))
				0: v = u;
				1: v = 16'h0000 - u;
				2: v = 16'h8000;
				default: v = 16'($urandom);
			endcase
			send_request(u, v);
		end
		calm = 1'b0;
		drain_results();
		repeat (60) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: errors");
		$finish;
	end
endmodule
